### rtl/pica_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pica_pkg: shared types and constants of the PI controller
// Word type of the shared arithmetic unit, its operation codes, register
// indexes, reset values and saturation codes.
// ----------------------------------------------------------------------------
package pica_pkg;

	localparam int DW       = 50;	// shared unit word: holds sums of 48-bit terms
	localparam int INTEG_W  = 48;
	localparam int ERR_W    = 17;
	localparam int GAIN_W   = 24;
	localparam int VOLT_W   = 16;
	localparam int DUTY_W   = 16;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int LIMIT_SHIFT = 20;
	localparam int MUL_A_W  = 25;
	localparam int MUL_B_W  = 18;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	typedef logic signed [DW-1:0]      word_t;
	typedef logic signed [INTEG_W-1:0] integ_t;

	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;
	localparam alu_op_t ALU_SUB = 2'd1;
	localparam alu_op_t ALU_MUL = 2'd2;

	typedef struct packed {
		alu_op_t op;
		word_t   a;
		word_t   b;
	} alu_req_t;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_SETPOINT = 3'd0;
	localparam reg_idx_t REG_KP_GAIN  = 3'd1;
	localparam reg_idx_t REG_KI_GAIN  = 3'd2;
	localparam reg_idx_t REG_DUTY_MAX = 3'd3;
	localparam reg_idx_t REG_DUTY_MIN = 3'd4;
	localparam reg_idx_t REG_PERIOD   = 3'd5;

	localparam logic [VOLT_W-1:0] RST_SETPOINT = 16'd13517;
	localparam logic [GAIN_W-1:0] RST_KP_GAIN  = 24'd838861;
	localparam logic [GAIN_W-1:0] RST_KI_GAIN  = 24'd8389;
	localparam logic [DUTY_W-1:0] RST_DUTY_MAX = 16'd58982;
	localparam logic [DUTY_W-1:0] RST_DUTY_MIN = 16'd6554;
	localparam logic [DUTY_W-1:0] RST_PERIOD   = 16'd1000;

	typedef logic [1:0] sat_t;
	localparam sat_t SAT_NONE = 2'd0;
	localparam sat_t SAT_HIGH = 2'd1;
	localparam sat_t SAT_LOW  = 2'd2;

	// clip a unit word to the signed 48-bit range
	function automatic integ_t sat48(input word_t v);
		integ_t r;
		if ((v[DW-1:INTEG_W-1] == '0) || (v[DW-1:INTEG_W-1] == '1))
			r = v[INTEG_W-1:0];
		else if (v[DW-1])
			r = {1'b1, {(INTEG_W-1){1'b0}}};
		else
			r = {1'b0, {(INTEG_W-1){1'b1}}};
		return r;
	endfunction

endpackage

### rtl/pica_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pica_if: request channels of the PI controller
// Sample channel (measured voltage) and result channel (duty, edge, code).
// ----------------------------------------------------------------------------
interface pica_in_if
	import pica_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [VOLT_W-1:0] measured_voltage;

	modport source (output valid, output measured_voltage, input ready);
	modport sink   (input valid, input measured_voltage, output ready);
endinterface

interface pica_out_if
	import pica_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty;
	logic [DUTY_W-1:0] fall_ticks;
	sat_t              saturation;

	modport source (output valid, output duty, output fall_ticks, output saturation,
		input ready);
	modport sink   (input valid, input duty, input fall_ticks, input saturation,
		output ready);
endinterface

### rtl/pica_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pica_alu: shared arithmetic unit
// Add, subtract or 25x18 signed multiply; result registered every cycle.
// ----------------------------------------------------------------------------
module pica_alu
	import pica_pkg::*;
(
	input  logic     clk,
	input  alu_req_t req,
	output word_t    res
);

	logic signed [PROD_W-1:0] prod;
	word_t                    res_d;
	word_t                    res_q;

	assign prod = $signed(req.a[MUL_A_W-1:0]) * $signed(req.b[MUL_B_W-1:0]);

	always_comb begin
		unique case (req.op)
			ALU_ADD: res_d = req.a + req.b;
			ALU_SUB: res_d = req.a - req.b;
			ALU_MUL: res_d = {{(DW-PROD_W){prod[PROD_W-1]}}, prod};
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign res = res_q;

endmodule

### rtl/pi_controller_anti_windup_top.sv
// A result is offered once its sample has walked the sequencer from ERR to DONE
// and the free result register has taken it. A new sample is taken only in IDLE,
// after the walk over the single shared add/subtract/multiply unit (one operation a cycle).
// The result register frees the sequencer as soon as the result is latched.
// Reset (arst_n, asynchronous, active low) loads the register defaults,
// clears the integrator and empties the result register.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_controller_anti_windup_top: PI duty controller with clamping anti-windup
// Sequencer around one shared arithmetic unit, configuration registers,
// integrator and result register.
// ----------------------------------------------------------------------------
module pi_controller_anti_windup_top
	import pica_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  reg_idx_t       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	pica_in_if.sink        sample,
	pica_out_if.source     result
);

	// sequencer codes, one shared-unit operation issued per state
	localparam logic [3:0] ST_IDLE = 4'd0;	// wait for a sample
	localparam logic [3:0] ST_ERR  = 4'd1;	// issue setpoint - sample
	localparam logic [3:0] ST_MULP = 4'd2;	// latch error, issue kp*err
	localparam logic [3:0] ST_MULI = 4'd3;	// latch P, issue ki*err
	localparam logic [3:0] ST_ADDI = 4'd4;	// issue integrator + ki*err
	localparam logic [3:0] ST_ADDS = 4'd5;	// clip integrator, issue P + integ
	localparam logic [3:0] ST_CMPH = 4'd6;	// latch sum, issue hi - sum
	localparam logic [3:0] ST_CMPL = 4'd7;	// latch high flag, issue sum - lo
	localparam logic [3:0] ST_BACK = 4'd8;	// choose duty, issue limit - P
	localparam logic [3:0] ST_FALL = 4'd9;	// back-calc integ, issue period*duty
	localparam logic [3:0] ST_DONE = 4'd10;	// hand over to the result register

	logic [3:0] state_q;

	// configuration
	logic [VOLT_W-1:0] setpoint_q;
	logic [GAIN_W-1:0] kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [DUTY_W-1:0] dmax_q;
	logic [DUTY_W-1:0] dmin_q;
	logic [DUTY_W-1:0] period_q;

	// working registers
	logic [VOLT_W-1:0] meas_q;
	logic [ERR_W-1:0]  err_q;
	word_t             p_q;
	word_t             sum_q;
	integ_t            integ_q;
	integ_t            integ_clip;
	logic              hi_q;
	logic [DUTY_W-1:0] duty_q;
	sat_t              sat_q;

	// result register
	logic              out_valid_q;
	logic [DUTY_W-1:0] out_duty_q;
	logic [DUTY_W-1:0] out_fall_q;
	sat_t              out_sat_q;

	alu_req_t req;
	word_t    res;
	word_t    hi_w;
	word_t    lo_w;
	logic     take_out;

	// limits moved to Q.36
	assign hi_w = {{(DW-DUTY_W-LIMIT_SHIFT){1'b0}}, dmax_q, {LIMIT_SHIFT{1'b0}}};
	assign lo_w = {{(DW-DUTY_W-LIMIT_SHIFT){1'b0}}, dmin_q, {LIMIT_SHIFT{1'b0}}};

	assign integ_clip = sat48(res);

	pica_alu u_alu (
		.clk (clk),
		.req (req),
		.res (res)
	);

	// operand selection for the shared unit
	always_comb begin
		req.op = ALU_MUL;
		req.a  = {{(DW-DUTY_W){1'b0}}, period_q};
		req.b  = {{(DW-DUTY_W){1'b0}}, duty_q};
		unique case (state_q)
			ST_ERR: begin
				req.op = ALU_SUB;
				req.a  = {{(DW-VOLT_W){1'b0}}, setpoint_q};
				req.b  = {{(DW-VOLT_W){1'b0}}, meas_q};
			end
			ST_MULP: begin
				req.op = ALU_MUL;
				req.a  = {{(DW-GAIN_W){1'b0}}, kp_q};
				req.b  = {{(DW-ERR_W){res[ERR_W-1]}}, res[ERR_W-1:0]};
			end
			ST_MULI: begin
				req.op = ALU_MUL;
				req.a  = {{(DW-GAIN_W){1'b0}}, ki_q};
				req.b  = {{(DW-ERR_W){err_q[ERR_W-1]}}, err_q};
			end
			ST_ADDI: begin
				req.op = ALU_ADD;
				req.a  = {{(DW-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
				req.b  = res;
			end
			ST_ADDS: begin
				req.op = ALU_ADD;
				req.a  = p_q;
				req.b  = {{(DW-INTEG_W){integ_clip[INTEG_W-1]}}, integ_clip};
			end
			ST_CMPH: begin
				req.op = ALU_SUB;
				req.a  = hi_w;
				req.b  = res;
			end
			ST_CMPL: begin
				req.op = ALU_SUB;
				req.a  = sum_q;
				req.b  = lo_w;
			end
			ST_BACK: begin
				// high clamp wins over low when the limits are crossed
				req.op = ALU_SUB;
				req.a  = hi_q ? hi_w : lo_w;
				req.b  = p_q;
			end
			default: begin
				// idle, edge product and hand-over keep period*duty in the unit
			end
		endcase
	end

	// result register: free when empty or being taken
	assign take_out = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
			setpoint_q  <= RST_SETPOINT;
			kp_q        <= RST_KP_GAIN;
			ki_q        <= RST_KI_GAIN;
			dmax_q      <= RST_DUTY_MAX;
			dmin_q      <= RST_DUTY_MIN;
			period_q    <= RST_PERIOD;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SETPOINT: setpoint_q <= cfg_data[VOLT_W-1:0];
					REG_KP_GAIN:  kp_q       <= cfg_data[GAIN_W-1:0];
					REG_KI_GAIN:  ki_q       <= cfg_data[GAIN_W-1:0];
					REG_DUTY_MAX: dmax_q     <= cfg_data[DUTY_W-1:0];
					REG_DUTY_MIN: dmin_q     <= cfg_data[DUTY_W-1:0];
					REG_PERIOD:   period_q   <= cfg_data[DUTY_W-1:0];
					default: ;	// unmapped index: ignored
				endcase
			end

			if (out_valid_q && result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid)
						state_q <= ST_ERR;
				end
				ST_ERR:  state_q <= ST_MULP;
				ST_MULP: state_q <= ST_MULI;
				ST_MULI: state_q <= ST_ADDI;
				ST_ADDI: state_q <= ST_ADDS;
				ST_ADDS: begin
					integ_q <= integ_clip;
					state_q <= ST_CMPH;
				end
				ST_CMPH: state_q <= ST_CMPL;
				ST_CMPL: state_q <= ST_BACK;
				ST_BACK: state_q <= ST_FALL;
				ST_FALL: begin
					// back-calculation: integrator = limit - P on a clamp
					if (sat_q != SAT_NONE)
						integ_q <= res[INTEG_W-1:0];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: meas_q <= sample.measured_voltage;
			ST_MULP: err_q  <= res[ERR_W-1:0];
			ST_MULI: p_q    <= res;
			ST_CMPH: sum_q  <= res;
			ST_CMPL: hi_q   <= res[DW-1];	// hi - sum < 0: above the top limit
			ST_BACK: begin
				if (hi_q) begin
					duty_q <= dmax_q;
					sat_q  <= SAT_HIGH;
				end else if (res[DW-1]) begin	// sum - lo < 0
					duty_q <= dmin_q;
					sat_q  <= SAT_LOW;
				end else begin
					// within limits the sum is nonnegative and below 2^36
					duty_q <= sum_q[LIMIT_SHIFT+DUTY_W-1:LIMIT_SHIFT];
					sat_q  <= SAT_NONE;
				end
			end
			ST_DONE: begin
				if (take_out) begin
					out_duty_q <= duty_q;
					out_fall_q <= res[2*DUTY_W-1:DUTY_W];
					out_sat_q  <= sat_q;
				end
			end
			default: ;
		endcase
	end

	assign sample.ready      = (state_q == ST_IDLE);
	assign result.valid      = out_valid_q;
	assign result.duty       = out_duty_q;
	assign result.fall_ticks = out_fall_q;
	assign result.saturation = out_sat_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> state_q == ST_ERR)
		else $error("sample taken but sequencer did not start");

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside hand-over");

	a_sat_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_sat_q == SAT_NONE || out_sat_q == SAT_HIGH ||
			out_sat_q == SAT_LOW))
		else $error("bad saturation code");

	a_clamp_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_sat_q == SAT_HIGH |-> out_duty_q == dmax_q)
		else $error("high clamp does not give the top limit");
`endif

endmodule
